>>> hw/rtl/midpoint_ellipse_raster_assert.svh
// Assertion macros for the ellipse rasterizer; they expect clk and arst_n in scope.
`ifndef MIDPOINT_ELLIPSE_RASTER_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MER_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ellipse raster check failed");
`define MER_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ellipse raster check failed");
`else
`define MER_ASSERT_IMP(lbl, ante, cons)
`define MER_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/mer_pkg.sv
// Shared types and constants of the midpoint ellipse rasterizer.
package mer_pkg;

	localparam int CENTER_W = 10;
	localparam int RADIUS_W = 9;
	localparam int OUT_W    = 12;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	typedef struct packed {
		logic                action;
		logic [CENTER_W-1:0] center_x;
		logic [CENTER_W-1:0] center_y;
		logic [RADIUS_W-1:0] radius_x;
		logic [RADIUS_W-1:0] radius_y;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] right_x;
		logic signed [OUT_W-1:0] left_x;
		logic signed [OUT_W-1:0] lower_y;
		logic signed [OUT_W-1:0] upper_y;
		logic                    last;
	} out_item_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_R1,
		PH_R2
	} ell_phase_t;

	typedef enum logic [3:0] {
		ST_WAIT,
		ST_SQX,
		ST_SQY,
		ST_RXRY,
		ST_SEED1,
		ST_TRUNC,
		ST_STEP,
		ST_TXSQ,
		ST_TYSQ,
		ST_PA,
		ST_PB,
		ST_PC,
		ST_PD,
		ST_EMIT
	} seq_state_t;

	typedef struct packed {
		logic       item_valid;
		logic       item_action;
		ell_phase_t phase;
		logic       r1_more;
		logic       out_free;
	} seq_stat_t;

	typedef struct packed {
		seq_state_t st;
		logic       ready;
		logic       take_start;
		logic       load_out;
		logic       r1_upd;
		logic       r2_upd;
	} seq_ctl_t;

endpackage

>>> hw/rtl/mer_mul.sv
// Shared unsigned multiplier with a registered product.
module mer_mul #(
	parameter int A_W = 18,
	parameter int B_W = 24
) (
	input  logic             clk,
	input  logic [A_W-1:0]   op_a,
	input  logic [B_W-1:0]   op_b,
	output logic [A_W+B_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule

>>> hw/rtl/mer_seq.sv
// Sequencer that schedules setup, stepping and region switch over the shared multiplier.
module mer_seq import mer_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  seq_stat_t stat,
	output seq_ctl_t  ctl
);

	seq_state_t state_q;
	seq_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WAIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_WAIT: begin
				if (stat.item_valid) begin
					if (stat.item_action == ACT_START) begin
						state_d = ST_SQX;
					end else if (stat.phase != PH_IDLE) begin
						state_d = ST_STEP;
					end
				end
			end
			ST_SQX:   state_d = ST_SQY;
			ST_SQY:   state_d = ST_RXRY;
			ST_RXRY:  state_d = ST_SEED1;
			ST_SEED1: state_d = ST_TRUNC;
			// seed 2 already moved the phase to region 2; its step still follows
			ST_TRUNC: state_d = (stat.phase == PH_R2) ? ST_STEP : ST_EMIT;
			ST_STEP: begin
				if (stat.phase == PH_R1 && !stat.r1_more) begin
					state_d = ST_TXSQ;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_TXSQ:  state_d = ST_TYSQ;
			ST_TYSQ:  state_d = ST_PA;
			ST_PA:    state_d = ST_PB;
			ST_PB:    state_d = ST_PC;
			ST_PC:    state_d = ST_PD;
			ST_PD:    state_d = ST_TRUNC;
			ST_EMIT: begin
				if (stat.out_free) begin
					state_d = ST_WAIT;
				end
			end
			default:  state_d = ST_WAIT;
		endcase
	end

	always_comb begin
		ctl.st         = state_q;
		ctl.ready      = (state_q == ST_WAIT);
		ctl.take_start = (state_q == ST_WAIT) && stat.item_valid &&
		                 (stat.item_action == ACT_START);
		ctl.load_out   = (state_q == ST_EMIT) && stat.out_free;
		ctl.r1_upd     = (state_q == ST_STEP) && (stat.phase == PH_R1) && stat.r1_more;
		ctl.r2_upd     = (state_q == ST_STEP) && (stat.phase == PH_R2);
	end

endmodule

>>> hw/rtl/midpoint_ellipse_raster.sv
// Top level of the midpoint ellipse rasterizer: datapath, output register, checks.
//
// Input channel item_valid/item_ready/item carries one command: action start loads
// center and radii and produces the first point; action step produces the next
// point. A step while no ellipse is active is taken and produces nothing.
// Output channel point_valid/point_ready/point carries one point per command:
// both mirrored x and both mirrored y coordinates, last set on the point with y
// offset zero, after which the block is idle until the next start.
// Steps, from a transfer on the input to the point loaded in the output register:
//   start: three squares/products through the one shared multiplier, then seed
//          and rounding.
//   step inside a region: one add/compare step, then output load.
//   step at the region 1 to 2 switch: five products for the seed.
// item_ready rises in the cycle after each point is loaded; the sequencer takes
// one item at a time.
// The output register decouples the sides: the next item is accepted while a
// point waits; a stalled receiver only holds the block in its output load.
// Reset clears the sequencer, the ellipse phase and point_valid.
`include "midpoint_ellipse_raster_assert.svh"

module midpoint_ellipse_raster import mer_pkg::*; #(
	parameter int COORD_BITS  = 10,
	parameter int RADIUS_BITS = 9
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      point_valid,
	input  logic      point_ready,
	output out_item_t point
);

	localparam int CB = (COORD_BITS < CENTER_W) ? COORD_BITS : CENTER_W;
	localparam int RB = (RADIUS_BITS < RADIUS_W) ? RADIUS_BITS : RADIUS_W;
	localparam int XW = RB + 2;
	localparam int SW = 3 * RB + 3;
	localparam int MA = 2 * RB;
	localparam int MB = 2 * RB + 6;
	localparam int PW = MA + MB;
	localparam int AW = PW + 2;

	seq_ctl_t  ctl;
	seq_stat_t stat;

	logic [CB-1:0]        ctr_x_q;
	logic [CB-1:0]        ctr_y_q;
	logic [RB-1:0]        rx_q;
	logic [RB-1:0]        ry_q;
	logic [MA-1:0]        rx2_q;
	logic [MA-1:0]        ry2_q;
	logic [XW-1:0]        off_x_q;
	logic [RB-1:0]        off_y_q;
	logic [SW-1:0]        slope_x_q;
	logic [SW-1:0]        slope_y_q;
	logic signed [AW-1:0] dec_q;
	logic signed [AW-1:0] acc_q;
	logic [MB-1:0]        tmp_q;
	ell_phase_t           phase_q;
	logic                 point_valid_q;
	out_item_t            point_q;

	logic [MA-1:0]        mul_a;
	logic [MB-1:0]        mul_b;
	logic [PW-1:0]        prod_q;

	logic [RB+2:0]        tx;
	logic [RB-1:0]        ty;
	logic [SW-1:0]        two_rx2;
	logic [SW-1:0]        two_ry2;
	logic [SW-1:0]        sx_inc;
	logic [SW-1:0]        sy_dec;
	logic [AW-1:0]        rx2_a;
	logic [AW-1:0]        ry2_a;
	logic [AW-1:0]        sx_a;
	logic [AW-1:0]        sy_a;
	logic [AW-1:0]        prod_a;
	logic [AW-1:0]        prod_a4;
	logic [AW-1:0]        two_a;
	logic signed [AW-1:0] tq;
	logic                 dec_neg;
	logic                 dec_pos;
	logic [OUT_W-1:0]     cx_o;
	logic [OUT_W-1:0]     cy_o;
	logic [OUT_W-1:0]     ox_o;
	logic [OUT_W-1:0]     oy_o;

	mer_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	mer_mul #(
		.A_W (MA),
		.B_W (MB)
	) u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod_q)
	);

	assign stat.item_valid  = item_valid;
	assign stat.item_action = item.action;
	assign stat.phase       = phase_q;
	assign stat.r1_more     = (slope_x_q < slope_y_q);
	assign stat.out_free    = !point_valid_q || point_ready;

	assign item_ready  = ctl.ready;
	assign point_valid = point_valid_q;
	assign point       = point_q;

	// region-switch seed terms: (2x+1) and (y-1)
	assign tx = {off_x_q, 1'b1};
	assign ty = off_y_q - {{(RB-1){1'b0}}, 1'b1};

	assign two_rx2 = {{(SW-MA-1){1'b0}}, rx2_q, 1'b0};
	assign two_ry2 = {{(SW-MA-1){1'b0}}, ry2_q, 1'b0};
	assign sx_inc  = slope_x_q + two_ry2;
	assign sy_dec  = slope_y_q - two_rx2;

	assign rx2_a   = {{(AW-MA){1'b0}}, rx2_q};
	assign ry2_a   = {{(AW-MA){1'b0}}, ry2_q};
	assign sx_a    = {{(AW-SW){1'b0}}, sx_inc};
	assign sy_a    = {{(AW-SW){1'b0}}, sy_dec};
	assign prod_a  = {2'b00, prod_q};
	assign prod_a4 = {prod_q, 2'b00};
	assign two_a   = {{(AW-2){1'b0}}, 2'b10};

	// quarter units truncated toward zero
	assign tq = acc_q + {{(AW-2){1'b0}}, acc_q[AW-1], acc_q[AW-1]};

	assign dec_neg = dec_q[AW-1];
	assign dec_pos = !dec_q[AW-1] && (|dec_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (ctl.st)
			ST_SQX: begin
				mul_a = {{(MA-RB){1'b0}}, rx_q};
				mul_b = {{(MB-RB){1'b0}}, rx_q};
			end
			ST_SQY: begin
				mul_a = {{(MA-RB){1'b0}}, ry_q};
				mul_b = {{(MB-RB){1'b0}}, ry_q};
			end
			ST_RXRY: begin
				mul_a = rx2_q;
				mul_b = {{(MB-RB){1'b0}}, ry_q};
			end
			ST_TXSQ: begin
				mul_a = {{(MA-RB-3){1'b0}}, tx};
				mul_b = {{(MB-RB-3){1'b0}}, tx};
			end
			ST_TYSQ: begin
				mul_a = {{(MA-RB){1'b0}}, ty};
				mul_b = {{(MB-RB){1'b0}}, ty};
			end
			ST_PA: begin
				mul_a = ry2_q;
				mul_b = tmp_q;
			end
			ST_PB: begin
				mul_a = rx2_q;
				mul_b = tmp_q;
			end
			ST_PC: begin
				mul_a = rx2_q;
				mul_b = {{(MB-MA){1'b0}}, ry2_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (ctl.st)
			ST_WAIT: begin
				if (ctl.take_start) begin
					ctr_x_q   <= item.center_x[CB-1:0];
					ctr_y_q   <= item.center_y[CB-1:0];
					rx_q      <= item.radius_x[RB-1:0];
					ry_q      <= item.radius_y[RB-1:0];
					off_x_q   <= '0;
					off_y_q   <= item.radius_y[RB-1:0];
					slope_x_q <= '0;
				end
			end
			ST_SQY:   rx2_q <= prod_q[MA-1:0];
			ST_RXRY:  ry2_q <= prod_q[MA-1:0];
			ST_SEED1: begin
				slope_y_q <= {prod_q[SW-2:0], 1'b0};
				acc_q     <= {ry2_a[AW-3:0], 2'b00} + rx2_a + two_a - prod_a4;
			end
			ST_TRUNC: dec_q <= tq >>> 2;
			ST_STEP: begin
				if (ctl.r1_upd) begin
					off_x_q   <= off_x_q + {{(XW-1){1'b0}}, 1'b1};
					slope_x_q <= sx_inc;
					if (dec_neg) begin
						dec_q <= dec_q + ry2_a + sx_a;
					end else begin
						off_y_q   <= off_y_q - {{(RB-1){1'b0}}, 1'b1};
						slope_y_q <= sy_dec;
						dec_q     <= dec_q + ry2_a + sx_a - sy_a;
					end
				end else if (ctl.r2_upd) begin
					off_y_q   <= off_y_q - {{(RB-1){1'b0}}, 1'b1};
					slope_y_q <= sy_dec;
					if (dec_pos) begin
						dec_q <= dec_q + rx2_a - sy_a;
					end else begin
						off_x_q   <= off_x_q + {{(XW-1){1'b0}}, 1'b1};
						slope_x_q <= sx_inc;
						dec_q     <= dec_q + rx2_a - sy_a + sx_a;
					end
				end
			end
			ST_TYSQ:  tmp_q <= prod_q[MB-1:0];
			ST_PA:    tmp_q <= prod_q[MB-1:0];
			ST_PB:    acc_q <= prod_a + two_a;
			ST_PC:    acc_q <= acc_q + prod_a4;
			ST_PD:    acc_q <= acc_q - prod_a4;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (ctl.take_start) begin
			phase_q <= PH_R1;
		end else if (ctl.st == ST_TXSQ) begin
			phase_q <= PH_R2;
		end else if (ctl.load_out && off_y_q == '0) begin
			phase_q <= PH_IDLE;
		end
	end

	assign cx_o = {{(OUT_W-CB){1'b0}}, ctr_x_q};
	assign cy_o = {{(OUT_W-CB){1'b0}}, ctr_y_q};
	assign ox_o = {{(OUT_W-XW){1'b0}}, off_x_q};
	assign oy_o = {{(OUT_W-RB){1'b0}}, off_y_q};

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			point_q.right_x <= cx_o + ox_o;
			point_q.left_x  <= cx_o - ox_o;
			point_q.lower_y <= cy_o + oy_o;
			point_q.upper_y <= cy_o - oy_o;
			point_q.last    <= (off_y_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			point_valid_q <= 1'b1;
		end else if (point_ready) begin
			point_valid_q <= 1'b0;
		end
	end

	`MER_ASSERT_IMP(a_no_overrun, ctl.load_out, !point_valid_q || point_ready)
	`MER_ASSERT_NXT(a_last_idles, ctl.load_out && off_y_q == '0, phase_q == PH_IDLE)
	`MER_ASSERT_IMP(a_r2_y_live, ctl.r2_upd, off_y_q != '0)
	`MER_ASSERT_IMP(a_step_active, ctl.st == ST_STEP, phase_q != PH_IDLE)

endmodule
